FILE: hdl/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg: shared types and constants for the ordered list
// Capacity, item and result structs, operation and status codes.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [CAPACITY-1:0] vec_type;
   typedef logic signed [31:0]  data_type;

   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_BACK  = 2'd1,
      MODE_DELETE     = 2'd2,
      MODE_FIND       = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_DONE  = 3'd0,
      STAT_FOUND = 3'd1,
      STAT_MISS  = 3'd2,
      STAT_FULL  = 3'd3
   } status_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] position;
      logic [6:0] length;
   } rsp_type;

   // Broadcast to every cell for the update cycle
   typedef struct packed {
      logic     apply;
      logic     full;
      mode_type mode;
   } cmd_type;

   function automatic logic [6:0] len_field(cnt_type c);
      logic [31:0] w;
      w = 32'(c);
      return w[6:0];
   endfunction

   function automatic logic [5:0] pos_field(idx_type p);
      logic [31:0] w;
      w = 32'(p);
      return w[5:0];
   endfunction

endpackage

FILE: hdl/ordered_list_insert_delete_find.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_find: ordered list with push, delete and find
// Row of storage cells with a shared first-match picker and a small sequencer.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, slot 0 being the head; every
// slot compares itself against the key at once and moves data one place
// to its neighbor in the update cycle. Pushes go through capture and update;
// delete or find go through capture, compare, pick lowest hit and update; the
// pick stage is a lowest-set-bit isolate over the whole row followed by a
// mask and a position encoder. One item is in flight at a time; the next
// request transfer is taken once the update cycle has run, even while the
// previous response still waits on rsp_stall. Every request gives exactly
// one response: status, position of the first match (find only) and the
// list length after the item. A push into a full list leaves the list as
// it is and answers full. No clearing pass follows reset: of the list state
// only the count is reset, and slots at or past it are never read.
module ordered_list_insert_delete_find (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  olist_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output olist_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MATCH = 4'b0010,
      ST_PICK  = 4'b0100,
      ST_APPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   olist_pkg::mode_type mode_ff, mode_in;
   olist_pkg::data_type key_ff, key_in;
   olist_pkg::cnt_type  count_ff, count_in;
   olist_pkg::rsp_type  rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic req_xfer;
   logic rsp_xfer;
   logic fire;          // update cycle runs
   logic full;

   olist_pkg::cmd_type  cmd;
   olist_pkg::vec_type  hits;
   olist_pkg::vec_type  occupied;
   olist_pkg::vec_type  at_tail;
   olist_pkg::vec_type  after_mask;
   logic                found;
   olist_pkg::idx_type  position;
   olist_pkg::data_type cell_data [olist_pkg::CAPACITY];

   // ---------------------------------------------------------------- handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // result register must be free (or draining this cycle) before an update
   assign fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign full = (count_ff == olist_pkg::cnt_type'(olist_pkg::CAPACITY));

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      key_in   = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in = olist_pkg::mode_type'(req_data.mode);
               key_in  = req_data.value;
               // pushes need no search
               if (req_data.mode == olist_pkg::MODE_PUSH_FRONT ||
                   req_data.mode == olist_pkg::MODE_PUSH_BACK) begin
                  state_in = ST_APPLY;
               end else begin
                  state_in = ST_MATCH;
               end
            end
         end
         ST_MATCH: state_in = ST_PICK;
         ST_PICK:  state_in = ST_APPLY;
         ST_APPLY: begin
            if (fire) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- cell row
   assign cmd.apply = fire;
   assign cmd.full  = full;
   assign cmd.mode  = mode_ff;

   for (genvar i = 0; i < olist_pkg::CAPACITY; i++) begin : g_cell
      olist_pkg::data_type prev_d;
      olist_pkg::data_type next_d;

      assign occupied[i] = (olist_pkg::cnt_type'(i) < count_ff);
      assign at_tail[i]  = (olist_pkg::cnt_type'(i) == count_ff);

      if (i == 0) begin : g_head
         assign prev_d = key_ff;               // head takes the pushed value
      end else begin : g_body
         assign prev_d = cell_data[i-1];
      end

      if (i == olist_pkg::CAPACITY - 1) begin : g_last
         assign next_d = cell_data[i];         // beyond the tail: don't care
      end else begin : g_inner
         assign next_d = cell_data[i+1];
      end

      olist_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .key         (key_ff),
         .prev_data   (prev_d),
         .next_data   (next_d),
         .occupied    (occupied[i]),
         .at_tail     (at_tail[i]),
         .after_match (after_mask[i]),
         .data        (cell_data[i]),
         .hit         (hits[i])
      );
   end

   olist_pick u_pick (
      .clock      (clock),
      .hits       (hits),
      .load_match (state_ff == ST_MATCH),
      .load_pick  (state_ff == ST_PICK),
      .after_mask (after_mask),
      .found      (found),
      .position   (position)
   );

   // ---------------------------------------------------------------- count and result
   always_comb begin
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) rsp_valid_in = 1'b0;
      if (fire) begin
         rsp_in.position = '0;
         unique case (mode_ff)
            olist_pkg::MODE_PUSH_FRONT,
            olist_pkg::MODE_PUSH_BACK: begin
               if (full) begin
                  rsp_in.status = olist_pkg::STAT_FULL;
               end else begin
                  rsp_in.status = olist_pkg::STAT_DONE;
                  count_in      = count_ff + 1'b1;
               end
            end
            olist_pkg::MODE_DELETE: begin
               if (found) begin
                  rsp_in.status = olist_pkg::STAT_DONE;
                  count_in      = count_ff - 1'b1;
               end else begin
                  rsp_in.status = olist_pkg::STAT_MISS;
               end
            end
            olist_pkg::MODE_FIND: begin
               if (found) begin
                  rsp_in.status   = olist_pkg::STAT_FOUND;
                  rsp_in.position = olist_pkg::pos_field(position);
               end else begin
                  rsp_in.status = olist_pkg::STAT_MISS;
               end
            end
         endcase
         rsp_in.length = olist_pkg::len_field(count_in);
         rsp_valid_in  = 1'b1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= olist_pkg::cnt_type'(olist_pkg::CAPACITY))
      else $error("list count above capacity");

   a_delete_shrinks : assert property (@(posedge clock) disable iff (reset)
      (fire && mode_ff == olist_pkg::MODE_DELETE && found)
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("delete hit did not shrink the list");

   a_rsp_from_update : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("response raised without an update cycle");

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_xfer) |=> (state_ff == ST_MATCH || state_ff == ST_APPLY))
      else $error("accepted request did not start work");
`endif

endmodule

FILE: hdl/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell: one list slot
// Holds one entry, compares it with the key and takes data from a neighbor.
// ----------------------------------------------------------------------------
module olist_cell (
   input  logic               clock,
   input  olist_pkg::cmd_type  cmd,
   input  olist_pkg::data_type key,
   input  olist_pkg::data_type prev_data,
   input  olist_pkg::data_type next_data,
   input  logic               occupied,
   input  logic               at_tail,
   input  logic               after_match,
   output olist_pkg::data_type data,
   output logic               hit
);

   olist_pkg::data_type data_ff;
   olist_pkg::data_type data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.apply) begin
         unique case (cmd.mode)
            olist_pkg::MODE_PUSH_FRONT: begin
               if (!cmd.full) data_in = prev_data;
            end
            olist_pkg::MODE_PUSH_BACK: begin
               if (!cmd.full && at_tail) data_in = key;
            end
            olist_pkg::MODE_DELETE: begin
               // compact: slots at and past the first match pull from the right
               if (after_match) data_in = next_data;
            end
            olist_pkg::MODE_FIND: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign hit  = occupied && (data_ff == key);

endmodule

FILE: hdl/olist_pick.sv
// ----------------------------------------------------------------------------
// olist_pick: first-match selection
// Registers the hit vector, isolates the lowest hit, encodes its position.
// ----------------------------------------------------------------------------
module olist_pick (
   input  logic               clock,
   input  olist_pkg::vec_type hits,
   input  logic               load_match,
   input  logic               load_pick,
   output olist_pkg::vec_type after_mask,
   output logic               found,
   output olist_pkg::idx_type position
);

   olist_pkg::vec_type match_ff, match_in;
   olist_pkg::vec_type lowest_ff, lowest_in;
   olist_pkg::vec_type one_vec;
   olist_pkg::idx_type pos_acc;

   assign one_vec = {{(olist_pkg::CAPACITY-1){1'b0}}, 1'b1};

   always_comb begin
      match_in  = load_match ? hits : match_ff;
      lowest_in = load_pick ? (match_ff & (~match_ff + one_vec)) : lowest_ff;
   end

   always_ff @(posedge clock) begin
      match_ff  <= match_in;
      lowest_ff <= lowest_in;
   end

   // all ones from the first hit upward; zero when nothing hit
   assign after_mask = ~(lowest_ff - one_vec);
   assign found      = |lowest_ff;

   always_comb begin
      pos_acc = '0;
      for (int i = 0; i < olist_pkg::CAPACITY; i++) begin
         if (lowest_ff[i]) pos_acc = pos_acc | olist_pkg::idx_type'(i);
      end
   end

   assign position = pos_acc;

endmodule

FILE: tb/olist_checker.sv
// ----------------------------------------------------------------------------
// olist_checker: shadow list and response check for the ordered list
// Watches both channels, replays each request on a private copy of the
// list and checks every response field against the oldest prediction.
// ----------------------------------------------------------------------------
module olist_checker
   import olist_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   data_type shadow_list [CAPACITY];
   int       list_fill;
   rsp_type  answers_due [$];

   // Apply one request to the shadow list and return the response it earns
   function automatic rsp_type apply_request(req_type item);
      rsp_type  answer;
      int       hit;
      int       i;
      mode_type op;
      answer = '0;
      hit    = -1;
      op     = mode_type'(item.mode);
      for (i = 0; i < list_fill; i++) begin
         if (hit < 0 && shadow_list[i] == item.value) begin
            hit = i;
         end
      end
      case (op)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (list_fill >= CAPACITY) begin
               answer.status = STAT_FULL;
            end else if (op == MODE_PUSH_FRONT) begin
               for (i = list_fill; i > 0; i--) begin
                  shadow_list[i] = shadow_list[i-1];
               end
               shadow_list[0] = item.value;
               list_fill++;
               answer.status = STAT_DONE;
            end else begin
               shadow_list[list_fill] = item.value;
               list_fill++;
               answer.status = STAT_DONE;
            end
         end
         MODE_DELETE: begin
            if (hit < 0) begin
               answer.status = STAT_MISS;
            end else begin
               for (i = hit; i + 1 < list_fill; i++) begin
                  shadow_list[i] = shadow_list[i+1];
               end
               list_fill--;
               answer.status = STAT_DONE;
            end
         end
         default: begin
            if (hit < 0) begin
               answer.status = STAT_MISS;
            end else begin
               answer.status   = STAT_FOUND;
               answer.position = 6'(hit);
            end
         end
      endcase
      answer.length = 7'(list_fill);
      return answer;
   endfunction

   function automatic void check_field(string name, int want, logic [6:0] got);
      if (got !== 7'(want)) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         answers_due.delete();
         list_fill = 0;
      end else begin
         // response side first: a same-edge request cannot own this response
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %0d/%0d/%0d",
                        $realtime, rsp_data.status, rsp_data.position, rsp_data.length);
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               check_field("status",   want.status,   7'(rsp_data.status));
               check_field("position", want.position, 7'(rsp_data.position));
               check_field("length",   want.length,   rsp_data.length);
            end
         end
         if (req_valid && !req_stall) begin
            answers_due = {answers_due, apply_request(req_data)};
         end
      end
      outstanding <= answers_due.size();
   end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: ordered list insert, delete and find
// Directed corner items, then phased random traffic (fill, mixed, drain)
// with random idling on both channels, one long response hold-off and one
// drain pause. Checking lives in olist_checker.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import olist_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int CALM_ITEMS   = 250;   // tail of the run with no idling
   localparam int LONG_HOLD    = 80;    // cycles of response back-pressure
   localparam int POOL_SIZE    = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      mismatches;
   int      outstanding;

   // Coordination with the response-side process
   logic    calm      = 1'b0;   // no idling on either side once set
   logic    hold_req  = 1'b0;   // toggled to ask for one long hold-off
   logic    hold_ack  = 1'b0;
   int      stall_left = 0;

   // Small value pool so that finds and deletes actually hit; extremes fixed
   data_type value_pool [POOL_SIZE];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ordered_list_insert_delete_find u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   olist_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Response side: short random stall bursts, or one long hold-off on request.
   // Exactly one assignment to rsp_stall per clock edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (hold_req != hold_ack) begin
         // long hold: the block fills up and has to push back on requests
         rsp_stall  <= 1'b1;
         stall_left <= LONG_HOLD - 1;
         hold_ack   <= hold_req;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Offer one request and hold it until the transfer happens.
   // An optional idle burst goes in front of it.
   task automatic offer(input mode_type op, input data_type value);
      if (!calm && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{mode: op, value: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering until every outstanding response has been taken.
   // The first edge lets the checker's count catch up with the last transfer.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic data_type pick_value();
      if ($urandom_range(0, 99) < 85) begin
         return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      return data_type'($urandom);
   endfunction

   // Mode mix per phase kind: 0 fill up, 1 mixed, 2 drain down
   function automatic mode_type pick_mode(int kind);
      int roll;
      roll = $urandom_range(0, 99);
      case (kind)
         0: begin
            if (roll < 45)      return MODE_PUSH_FRONT;
            else if (roll < 85) return MODE_PUSH_BACK;
            else if (roll < 92) return MODE_DELETE;
            else                return MODE_FIND;
         end
         1: begin
            if (roll < 25)      return MODE_PUSH_FRONT;
            else if (roll < 50) return MODE_PUSH_BACK;
            else if (roll < 75) return MODE_DELETE;
            else                return MODE_FIND;
         end
         default: begin
            if (roll < 10)      return MODE_PUSH_FRONT;
            else if (roll < 20) return MODE_PUSH_BACK;
            else if (roll < 75) return MODE_DELETE;
            else                return MODE_FIND;
         end
      endcase
   endfunction

   initial begin
      int sent;
      int phase;
      int phase_len;
      int n;
      int i;

      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = 32'sh0000_0000;
      value_pool[3] = 32'shFFFF_FFFF;
      for (i = 4; i < POOL_SIZE; i++) value_pool[i] = data_type'($urandom);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed corners ----
      offer(MODE_FIND,       32'sh0000_0000);   // find on empty list
      offer(MODE_DELETE,     32'sh0000_0000);   // delete on empty list
      offer(MODE_PUSH_BACK,  32'sh7FFF_FFFF);
      offer(MODE_PUSH_FRONT, 32'sh8000_0000);
      offer(MODE_PUSH_BACK,  32'shFFFF_FFFF);
      offer(MODE_PUSH_FRONT, 32'sh0000_0000);
      offer(MODE_FIND,       32'sh8000_0000);   // interior hit
      offer(MODE_FIND,       32'shFFFF_FFFF);   // hit at the tail
      offer(MODE_PUSH_BACK,  32'sh5A5A_5A5A);
      offer(MODE_PUSH_BACK,  32'sh5A5A_5A5A);   // duplicate
      offer(MODE_FIND,       32'sh5A5A_5A5A);   // first of the duplicates
      offer(MODE_DELETE,     32'sh5A5A_5A5A);   // removes only the first
      offer(MODE_FIND,       32'sh5A5A_5A5A);
      offer(MODE_DELETE,     32'sh0001_2345);   // miss on a non-empty list
      offer(MODE_FIND,       32'sh0001_2345);
      offer(MODE_DELETE,     32'sh0000_0000);   // delete the head
      offer(MODE_DELETE,     32'shFFFF_FFFF);   // delete from the middle
      offer(MODE_PUSH_FRONT, 32'shA5A5_A5A5);
      offer(MODE_DELETE,     32'sh7FFF_FFFF);
      offer(MODE_FIND,       32'sh8000_0000);
      offer(MODE_FIND,       32'shA5A5_A5A5);   // hit at the head

      // ---- random phases: fill pushes past capacity, drain empties again ----
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(100, 180);
         if (phase == 2) hold_req <= ~hold_req;   // sender keeps offering meanwhile
         for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
            if (!calm && sent >= RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
            offer(pick_mode(phase % 3), pick_value());
            sent++;
         end
         if (phase == 1) drain_responses();
         // refresh part of the pool so fresh bit patterns come in
         for (i = 4; i < POOL_SIZE; i++) begin
            if ($urandom_range(0, 2) == 0) value_pool[i] = data_type'($urandom);
         end
         phase++;
      end

      drain_responses();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("** ordered_list_insert_delete_find: PASSED **");
      end else begin
         $display("** ordered_list_insert_delete_find: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #400000;
      $display("** ordered_list_insert_delete_find: FAILED **");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/olist_pkg.sv
hdl/olist_cell.sv
hdl/olist_pick.sv
hdl/ordered_list_insert_delete_find.sv
tb/olist_checker.sv
tb/testbench.sv
